>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LPH_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define LPH_ASSERT_NORST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`else

`define LPH_ASSERT(name, prop)

`define LPH_ASSERT_NORST(name, prop)

`endif

`endif

>>> sv/lph_pkg.sv
package lph_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned ITEM_W      = 32;
  localparam int unsigned SLOT_OUT_W  = 6;
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  key_hash;
    logic [ITEM_W-1:0] item_handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic [ITEM_W-1:0]      found_item;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]  hash;
    logic [ITEM_W-1:0] item;
  } slot_t;

endpackage

>>> sv/lph_stream_if.sv
interface lph_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/lph_mod.sv
module lph_mod #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lph_pkg::KEY_W-1:0] key_i,
  output logic                      done_o,
  output logic [IDX_W-1:0]          rem_o
);
  import lph_pkg::*;

  localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam int unsigned SHIFT  = KEY_W + IDX_W;
  localparam int unsigned PROD_W = 2 * KEY_W + 1;
  localparam logic [63:0] SCALE = 64'd1 << SHIFT;
  localparam logic [KEY_W:0] RECIP =
    (KEY_W + 1)'((SCALE + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [IDX_W-1:0] MOD_LO = IDX_W'(SLOTS);

  logic              busy_q, busy_d;
  logic              phase_q, phase_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0]  quot_q;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  back;

  // quotient by reciprocal multiplication, remainder from the low bits
  assign prod = PROD_W'(key_q) * PROD_W'(RECIP);
  assign back = quot_q * MOD_LO;

  assign done_o = busy_q && (IS_POW2 || phase_q);
  assign rem_o  = IS_POW2 ? key_q[IDX_W-1:0] : key_q[IDX_W-1:0] - back;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    key_d   = key_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      key_d   = key_i;
    end else if (busy_q) begin
      phase_d = 1'b1;
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    key_q   <= key_d;
    quot_q  <= prod[SHIFT +: IDX_W];
  end

endmodule

>>> sv/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing over SLOTS slots held in one single-port-read
// synchronous memory of {hash, item} entries; a zero item marks an empty slot. After reset the
// block clears the memory one slot a cycle and takes no word until that is done. One word at a
// time: an accepted word first has its home slot computed (key_hash modulo SLOTS, from the low
// bits when SLOTS is a power of two, by reciprocal multiplication otherwise), then probes one
// slot per cycle, bounded by the memory read port, and the S_DONE state hands the result to the
// output register once that register is free. A probe run covers from 1 to SLOTS slots; an
// insert of handle zero skips the modulo and the probes and is answered with not found. A result
// waiting on the output does not hold back the next input word.
`include "assert_macros.svh"

module linear_probe_hash_table #(
  parameter int unsigned SLOTS = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  lph_stream_if.sink   in_i,
  lph_stream_if.source out_o
);
  import lph_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  function automatic out_word_t make_res(status_e st, logic [IDX_W-1:0] idx,
                                         logic [ITEM_W-1:0] item, logic [CNT_W-1:0] cnt);
    out_word_t r;
    r.status      = st;
    r.slot_index  = SLOT_OUT_W'(idx);
    r.found_item  = item;
    r.entry_count = COUNT_OUT_W'(cnt);
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [ITEM_W-1:0] item_q;
  logic [IDX_W-1:0]  pos_q, pos_d, pos_inc;
  logic [IDX_W-1:0]  probes_q, probes_d;
  out_word_t         res_q, res_d;
  out_word_t         out_q;
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic              in_fire;

  logic              mod_start;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;

  slot_t             slot_mem [SLOTS];
  slot_t             rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  slot_t             mem_wd;

  lph_mod #(
    .SLOTS(SLOTS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (in_i.data.key_hash),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign pos_inc = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    probes_d  = probes_q;
    res_d     = res_q;
    mod_start = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = pos_q;
    mem_wd    = '{hash: key_q, item: item_q};
    mem_ra    = pos_q;
    out_load  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.data.command == CMD_INSERT && in_i.data.item_handle == '0) begin
            res_d   = make_res(ST_NOT_FOUND, '0, '0, cnt_q);
            state_d = S_DONE;
          end else begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        mem_ra = mod_rem;
        if (mod_done) begin
          pos_d    = mod_rem;
          probes_d = '0;
          state_d  = S_PROBE;
        end
      end
      S_PROBE: begin
        mem_ra = pos_inc;
        if (cmd_q == CMD_INSERT) begin
          if (rd_q.item == '0) begin
            mem_we  = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            res_d   = make_res(ST_INSERTED, pos_q, '0, CNT_W'(cnt_q + 1'b1));
            state_d = S_DONE;
          end else if (probes_q == LAST_IDX) begin
            res_d   = make_res(ST_FULL, '0, '0, cnt_q);
            state_d = S_DONE;
          end else begin
            pos_d    = pos_inc;
            probes_d = probes_q + 1'b1;
          end
        end else begin
          if (rd_q.item == '0) begin
            res_d   = make_res(ST_NOT_FOUND, '0, '0, cnt_q);
            state_d = S_DONE;
          end else if (rd_q.hash == key_q) begin
            res_d   = make_res(ST_FOUND, pos_q, rd_q.item, cnt_q);
            state_d = S_DONE;
          end else if (probes_q == LAST_IDX) begin
            res_d   = make_res(ST_NOT_FOUND, '0, '0, cnt_q);
            state_d = S_DONE;
          end else begin
            pos_d    = pos_inc;
            probes_d = probes_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_i.data.command;
      key_q  <= in_i.data.key_hash;
      item_q <= in_i.data.item_handle;
    end
    pos_q    <= pos_d;
    probes_q <= probes_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // slot store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_q <= slot_mem[mem_ra];
  end

  `LPH_ASSERT(count_bounded_a, cnt_q <= FULL_CNT)
  `LPH_ASSERT(count_steps_a, cnt_q != $past(cnt_q) |-> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
  `LPH_ASSERT(mod_done_in_mod_a, mod_done |-> state_q == S_MOD)
  `LPH_ASSERT(full_means_full_a, out_valid_q && out_q.status == ST_FULL |-> cnt_q == FULL_CNT)

endmodule
